FILE: rtl/frcm_pkg.sv
// ----------------------------------------------------------------------------
// frcm_pkg
// Types and constants shared by the five-rotor cipher machine modules.
// ----------------------------------------------------------------------------
package frcm_pkg;

  localparam int LETTER_W    = 5;
  localparam int SEL_W       = 3;
  localparam int IDX_W       = 3;
  localparam int NUM_ROTORS  = 5;
  localparam int TABLE_SLOTS = 1 << LETTER_W;
  localparam int MEM_AW      = SEL_W + LETTER_W;
  localparam int MEM_DEPTH   = 1 << MEM_AW;
  localparam int STG_W       = 3;

  localparam logic [SEL_W-1:0] TBL_ENTRY  = 3'd0;
  localparam logic [SEL_W-1:0] TBL_EXIT   = 3'd6;
  localparam logic [SEL_W-1:0] TBL_NONE   = 3'd7;
  localparam logic [STG_W-1:0] LAST_STAGE = 3'd6;

  localparam logic [LETTER_W-1:0] TURNOVER_RESET = 5'd13;

  typedef enum logic [1:0] {
    OP_ENCRYPT = 2'd0,
    OP_DECRYPT = 2'd1,
    OP_LOAD    = 2'd2,
    OP_RESTART = 2'd3
  } opcode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_START_ONE   = 3'd0,
    REG_START_TWO   = 3'd1,
    REG_START_THREE = 3'd2,
    REG_START_FOUR  = 3'd3,
    REG_START_FIVE  = 3'd4,
    REG_FAST_TO     = 3'd5,
    REG_SEMI_TO     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [LETTER_W-1:0] in_letter;
    logic [SEL_W-1:0]    table_select;
    logic [LETTER_W-1:0] entry_index;
    logic [LETTER_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_letter;
    logic                was_decrypt;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ISSUE  = 2'd1,
    ST_RUN    = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue_first;
    logic run;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic letter_op;
    logic last;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/frcm_ctrl.sv
// ----------------------------------------------------------------------------
// frcm_ctrl
// Sequencer for one transaction: accept, first table read, seven stage
// steps, then hand-off to the output register.
// ----------------------------------------------------------------------------
module frcm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  frcm_pkg::status_t status,
  output frcm_pkg::cmd_t    cmd
);
  import frcm_pkg::*;

  state_t st_r;
  state_t st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid && status.letter_op) st_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        st_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (status.last) st_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.issue_first = 1'b0;
    cmd.run         = 1'b0;
    cmd.commit      = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_ISSUE: begin
        cmd.issue_first = 1'b1;
      end
      ST_RUN: begin
        cmd.run = 1'b1;
      end
      ST_FINISH: begin
        cmd.commit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_last_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN && status.last) |=> (st_r == ST_FINISH))
    else $error("last stage did not lead to finish");

  a_letter_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && status.letter_op) |=> (st_r == ST_ISSUE && !in_ready))
    else $error("letter transaction did not start the stage sequence");

endmodule

FILE: rtl/frcm_dpath.sv
// ----------------------------------------------------------------------------
// frcm_dpath
// Table memories, rotor positions, configuration registers, stage
// arithmetic and the output register.
// ----------------------------------------------------------------------------
module frcm_dpath #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  frcm_pkg::in_item_t      in_data,
  input  logic                    cfg_we,
  input  logic [frcm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [frcm_pkg::LETTER_W-1:0] cfg_wdata,
  output logic                    out_valid,
  input  logic                    out_ready,
  output frcm_pkg::out_item_t     out_data,
  input  frcm_pkg::cmd_t          cmd,
  output frcm_pkg::status_t       status
);
  import frcm_pkg::*;

  localparam logic [LETTER_W:0]   N6  = (LETTER_W+1)'(ALPHABET_SIZE);
  localparam logic [LETTER_W-1:0] NM1 = LETTER_W'(ALPHABET_SIZE - 1);

  function automatic logic [TABLE_SLOTS-1:0][LETTER_W-1:0] build_mod();
    logic [TABLE_SLOTS-1:0][LETTER_W-1:0] t;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      t[i] = LETTER_W'(i % ALPHABET_SIZE);
    end
    return t;
  endfunction

  localparam logic [TABLE_SLOTS-1:0][LETTER_W-1:0] MOD_TBL = build_mod();

  function automatic logic [LETTER_W-1:0] add_mod(logic [LETTER_W-1:0] a,
                                                  logic [LETTER_W-1:0] b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= N6) ? LETTER_W'(s - N6) : LETTER_W'(s);
  endfunction

  function automatic logic [LETTER_W-1:0] sub_mod(logic [LETTER_W-1:0] a,
                                                  logic [LETTER_W-1:0] b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + N6 - {1'b0, b};
    return (a >= b) ? (a - b) : LETTER_W'(s);
  endfunction

  function automatic logic [LETTER_W-1:0] inc_mod(logic [LETTER_W-1:0] a);
    return (a == NM1) ? '0 : (a + 1'b1);
  endfunction

  function automatic logic [SEL_W-1:0] stage_tbl(logic [STG_W-1:0] s, logic dec);
    return dec ? SEL_W'(TBL_EXIT - s) : s;
  endfunction

  function automatic logic [LETTER_W-1:0] pos_of(
      logic [SEL_W-1:0] t, logic [NUM_ROTORS-1:0][LETTER_W-1:0] lv);
    logic [LETTER_W-1:0] p;
    p = '0;
    if (t != TBL_ENTRY && t != TBL_EXIT && t != TBL_NONE) begin
      p = lv[SEL_W'(t - 1'b1)];
    end
    return p;
  endfunction

  // configuration
  logic [NUM_ROTORS-1:0][LETTER_W-1:0] start_pos_r;
  logic [LETTER_W-1:0] fast_to_r;
  logic [LETTER_W-1:0] semi_to_r;

  // live state
  logic [NUM_ROTORS-1:0][LETTER_W-1:0] live_r;
  logic [NUM_ROTORS-1:0][LETTER_W-1:0] live_nxt;

  // working registers
  logic [LETTER_W-1:0] x_r;
  logic                dec_r;
  logic [STG_W-1:0]    stg_r;
  logic [LETTER_W-1:0] rd_fwd_r;
  logic [LETTER_W-1:0] rd_inv_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [LETTER_W-1:0] fwd_mem [MEM_DEPTH];
  logic [LETTER_W-1:0] inv_mem [MEM_DEPTH];

  logic [LETTER_W-1:0] rd_sel;
  logic [LETTER_W-1:0] y;
  logic [STG_W-1:0]    iss_stage;
  logic [SEL_W-1:0]    iss_tbl;
  logic [LETTER_W-1:0] iss_x;
  logic [MEM_AW-1:0]   raddr;
  logic                load_ok;
  logic                fast_hit;
  logic                semi_hit;

  assign rd_sel    = dec_r ? rd_inv_r : rd_fwd_r;
  assign y         = sub_mod(rd_sel, pos_of(stage_tbl(stg_r, dec_r), live_r));
  assign iss_stage = cmd.issue_first ? '0 : (stg_r + 1'b1);
  assign iss_x     = cmd.issue_first ? x_r : y;
  assign iss_tbl   = stage_tbl(iss_stage, dec_r);
  assign raddr     = {iss_tbl, add_mod(iss_x, pos_of(iss_tbl, live_r))};

  assign load_ok = cmd.accept && (in_data.opcode == OP_LOAD) &&
                   (in_data.table_select != TBL_NONE) &&
                   ({1'b0, in_data.entry_index} < N6) &&
                   ({1'b0, in_data.entry_value} < N6);

  assign fast_hit = (live_r[4] == fast_to_r);
  assign semi_hit = (live_r[0] == semi_to_r);

  always_comb begin
    live_nxt = live_r;
    if (cmd.accept && in_data.opcode == OP_RESTART) begin
      for (int k = 0; k < NUM_ROTORS; k++) begin
        live_nxt[k] = MOD_TBL[start_pos_r[k]];
      end
    end else if (cmd.commit) begin
      live_nxt[4] = inc_mod(live_r[4]);
      if (fast_hit) live_nxt[0] = inc_mod(live_r[0]);
      if (fast_hit && semi_hit) live_nxt[2] = inc_mod(live_r[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r <= '0;
      fast_to_r   <= TURNOVER_RESET;
      semi_to_r   <= TURNOVER_RESET;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_START_ONE:   start_pos_r[0] <= cfg_wdata;
          REG_START_TWO:   start_pos_r[1] <= cfg_wdata;
          REG_START_THREE: start_pos_r[2] <= cfg_wdata;
          REG_START_FOUR:  start_pos_r[3] <= cfg_wdata;
          REG_START_FIVE:  start_pos_r[4] <= cfg_wdata;
          REG_FAST_TO:     fast_to_r      <= cfg_wdata;
          REG_SEMI_TO:     semi_to_r      <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r   <= MOD_TBL[in_data.in_letter];
      dec_r <= (in_data.opcode == OP_DECRYPT);
    end else if (cmd.run) begin
      x_r <= y;
    end
    if (cmd.issue_first) begin
      stg_r <= '0;
    end else if (cmd.run) begin
      stg_r <= stg_r + 1'b1;
    end
    if (cmd.commit) begin
      out_data_r.out_letter  <= x_r;
      out_data_r.was_decrypt <= dec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      fwd_mem[{in_data.table_select, in_data.entry_index}] <= in_data.entry_value;
      inv_mem[{in_data.table_select, in_data.entry_value}] <= in_data.entry_index;
    end
    rd_fwd_r <= fwd_mem[raddr];
    rd_inv_r <= inv_mem[raddr];
  end

  assign status.letter_op = !in_data.opcode[1];
  assign status.last      = (stg_r == LAST_STAGE);
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && out_data_r.was_decrypt == $past(dec_r)))
    else $error("committed result not presented");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, live_r[0]} < N6) && ({1'b0, live_r[2]} < N6) &&
    ({1'b0, live_r[4]} < N6))
    else $error("rotor position out of alphabet range");

endmodule

FILE: rtl/five_rotor_cipher_machine_top.sv
// ----------------------------------------------------------------------------
// five_rotor_cipher_machine_top
// Five-rotor letter cipher with loadable wirings.
//
// Input channel in_valid/in_ready/in_data carries one transaction per
// command: encrypt, decrypt, load table entry or restart positions.
// Loads and restarts complete in the accept cycle and give no result.
// A letter runs seven table stages, one memory read per cycle from the
// forward or inverse table memory; its result goes from the finish state
// into the output register on out_valid/out_ready/out_data, and no new
// transaction is taken until the letter has left the finish state, as the
// read ports walk the seven stages after the issue state.
// A waiting result sits in the output register; a letter that finishes
// while the receiver stalls waits in the finish state until that register frees.
// The cfg_ write port sets start positions and turnovers; the user takes it only idle, unenforced.
// Reset clears positions, turnovers go to 13, tables are unknown until
// loaded; no clearing pass is run.
// ----------------------------------------------------------------------------
module five_rotor_cipher_machine_top #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  frcm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output frcm_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [frcm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [frcm_pkg::LETTER_W-1:0] cfg_wdata
);
  import frcm_pkg::*;

  cmd_t    cmd;
  status_t status;

  frcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  frcm_dpath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
